[hw/rtl/image_diff_compare_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the image diff compare unit
// Clocked, reset-qualified implication checks reporting through $error.
// ----------------------------------------------------------------------------
`ifndef IMAGE_DIFF_COMPARE_UNIT_ASSERT_SVH
`define IMAGE_DIFF_COMPARE_UNIT_ASSERT_SVH

// same-cycle implication
`define IDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/idc_pkg.sv]
// ----------------------------------------------------------------------------
// idc_pkg
// Types and constants shared by the image diff compare unit.
// ----------------------------------------------------------------------------
package idc_pkg;

	localparam int CH_W     = 8;
	localparam int CNT_W    = 25;
	localparam int SUM_W    = 34;
	localparam int PSUM_W   = 10;
	localparam int CFG_W    = 25;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISMATCH = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] actual_red;
		logic [CH_W-1:0] actual_green;
		logic [CH_W-1:0] actual_blue;
		logic [CH_W-1:0] actual_alpha;
		logic [CH_W-1:0] expected_red;
		logic [CH_W-1:0] expected_green;
		logic [CH_W-1:0] expected_blue;
		logic [CH_W-1:0] expected_alpha;
		logic            last_pixel;
	} idc_in_t;

	typedef struct packed {
		logic             pass;
		logic [CNT_W-1:0] mismatch_count;
		logic [CH_W-1:0]  max_channel_diff;
		logic [SUM_W-1:0] diff_sum;
		logic [CNT_W-1:0] pixel_count;
	} idc_out_t;

	function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

[hw/rtl/image_diff_compare_unit.sv]
// ----------------------------------------------------------------------------
// image_diff_compare_unit
// A last pixel's result is registered first in the input register, then in the result register.
// Throughput: one pixel pair per cycle; the input register and the result
// register decouple the two channels, so only a last pixel waits on a full
// result register. Reset clears the configuration registers, accumulators
// and valid flags.
// ----------------------------------------------------------------------------
`include "image_diff_compare_unit_assert.svh"

module image_diff_compare_unit #(
	parameter longint unsigned MAX_PIXELS = 16777216
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  idc_pkg::idc_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output idc_pkg::idc_out_t                    out_data,
	input  logic                                 cfg_we,
	input  logic [idc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [idc_pkg::CFG_W-1:0]            cfg_data
);

	localparam longint unsigned PIX_FIELD_MAX = 64'h1FF_FFFF;
	localparam longint unsigned SUM_FIELD_MAX = 64'h3_FFFF_FFFF;
	localparam longint unsigned PIX_CAP_L =
		(MAX_PIXELS < PIX_FIELD_MAX) ? MAX_PIXELS : PIX_FIELD_MAX;
	localparam longint unsigned SUM_CAP_L =
		(64'd1020 * PIX_CAP_L < SUM_FIELD_MAX) ? 64'd1020 * PIX_CAP_L : SUM_FIELD_MAX;
	localparam logic [idc_pkg::CNT_W-1:0] PIX_CAP = idc_pkg::CNT_W'(PIX_CAP_L);
	localparam logic [idc_pkg::SUM_W-1:0] SUM_CAP = idc_pkg::SUM_W'(SUM_CAP_L);

	logic [idc_pkg::CH_W-1:0]   tolerance_q;
	logic [idc_pkg::CNT_W-1:0]  max_mismatch_q;

	logic                       valid_s1;
	idc_pkg::idc_in_t           item_s1;

	logic [idc_pkg::CNT_W-1:0]  mismatch_acc_q;
	logic [idc_pkg::SUM_W-1:0]  diff_acc_q;
	logic [idc_pkg::CH_W-1:0]   max_diff_acc_q;
	logic [idc_pkg::CNT_W-1:0]  pixel_acc_q;

	logic                       out_valid_q;
	idc_pkg::idc_out_t          out_data_q;

	logic [idc_pkg::CH_W-1:0]   diff [4];
	logic [idc_pkg::PSUM_W-1:0] pix_sum;
	logic                       miss;
	logic [idc_pkg::CH_W-1:0]   max_next;
	logic [idc_pkg::SUM_W:0]    diff_wide;
	logic [idc_pkg::SUM_W-1:0]  diff_next;
	logic [idc_pkg::CNT_W-1:0]  pixel_next;
	logic [idc_pkg::CNT_W-1:0]  mismatch_next;
	logic                       res_free;
	logic                       adv_s1;
	logic                       load_res;

	assign res_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!item_s1.last_pixel || res_free);
	assign load_res = adv_s1 && item_s1.last_pixel;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q    <= '0;
			max_mismatch_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				idc_pkg::CFG_TOLERANCE:    tolerance_q    <= cfg_data[idc_pkg::CH_W-1:0];
				idc_pkg::CFG_MAX_MISMATCH: max_mismatch_q <= cfg_data[idc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		diff[0] = idc_pkg::abs_diff(item_s1.actual_red,   item_s1.expected_red);
		diff[1] = idc_pkg::abs_diff(item_s1.actual_green, item_s1.expected_green);
		diff[2] = idc_pkg::abs_diff(item_s1.actual_blue,  item_s1.expected_blue);
		diff[3] = idc_pkg::abs_diff(item_s1.actual_alpha, item_s1.expected_alpha);
		pix_sum = idc_pkg::PSUM_W'(diff[0]) + idc_pkg::PSUM_W'(diff[1])
			+ idc_pkg::PSUM_W'(diff[2]) + idc_pkg::PSUM_W'(diff[3]);
		miss     = 1'b0;
		max_next = max_diff_acc_q;
		for (int i = 0; i < 4; i++) begin
			if (diff[i] > tolerance_q) begin
				miss = 1'b1;
			end
			if (diff[i] > max_next) begin
				max_next = diff[i];
			end
		end
		diff_wide = {1'b0, diff_acc_q} + (idc_pkg::SUM_W+1)'(pix_sum);
		diff_next = (diff_wide > {1'b0, SUM_CAP}) ? SUM_CAP : diff_wide[idc_pkg::SUM_W-1:0];
		pixel_next = (pixel_acc_q < PIX_CAP) ? pixel_acc_q + 1'b1 : pixel_acc_q;
		mismatch_next = (miss && (mismatch_acc_q < PIX_CAP)) ?
			mismatch_acc_q + 1'b1 : mismatch_acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_acc_q <= '0;
			diff_acc_q     <= '0;
			max_diff_acc_q <= '0;
			pixel_acc_q    <= '0;
		end else if (load_res) begin
			mismatch_acc_q <= '0;
			diff_acc_q     <= '0;
			max_diff_acc_q <= '0;
			pixel_acc_q    <= '0;
		end else if (adv_s1) begin
			mismatch_acc_q <= mismatch_next;
			diff_acc_q     <= diff_next;
			max_diff_acc_q <= max_next;
			pixel_acc_q    <= pixel_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			out_data_q.pass             <= (mismatch_next <= max_mismatch_q);
			out_data_q.mismatch_count   <= mismatch_next;
			out_data_q.max_channel_diff <= max_next;
			out_data_q.diff_sum         <= diff_next;
			out_data_q.pixel_count      <= pixel_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`IDC_ASSERT_NOW(a_hold_last, clk, arst_n, valid_s1 && item_s1.last_pixel && out_valid_q && out_stall, in_stall, "last pixel advanced into a full result register")
	`IDC_ASSERT_NEXT(a_clear_on_result, clk, arst_n, load_res, out_valid_q && pixel_acc_q == '0 && diff_acc_q == '0, "accumulators not cleared after result load")
	`IDC_ASSERT_NOW(a_pixel_cap, clk, arst_n, 1'b1, pixel_acc_q <= PIX_CAP && mismatch_acc_q <= pixel_acc_q, "pixel or mismatch count beyond cap")
	`IDC_ASSERT_NOW(a_sum_cap, clk, arst_n, 1'b1, diff_acc_q <= SUM_CAP, "difference sum beyond cap")

endmodule
